// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// File: hw/rtl/cesc_pkg.sv
// Types and constants for the call edge sample counter.
// No dependencies.
`default_nettype none
package cesc_pkg;

    localparam logic [7:0] CALL_OPCODE = 8'hE8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic REG_IMAGE_BASE = 1'b0;
    localparam logic REG_IMAGE_END  = 1'b1;

    localparam logic [1:0] ACT_RECORD = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [2:0] ST_NOT_CODE    = 3'd0;
    localparam logic [2:0] ST_NO_CALL     = 3'd1;
    localparam logic [2:0] ST_CALLEE_OUT  = 3'd2;
    localparam logic [2:0] ST_INCREMENTED = 3'd3;
    localparam logic [2:0] ST_INSERTED    = 3'd4;
    localparam logic [2:0] ST_FULL        = 3'd5;
    localparam logic [2:0] ST_READ        = 3'd6;
    localparam logic [2:0] ST_CLEARED     = 3'd7;

    typedef enum logic [1:0] {
        KIND_REJECT,
        KIND_RECORD,
        KIND_READ,
        KIND_CLEAR
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CMP
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  status;
        logic [31:0] caller_rva;
        logic [31:0] callee_rva;
        logic [9:0]  entry_index;
        logic        last;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] caller_rva;
        logic [31:0] callee_rva;
        logic [31:0] hit_count;
        logic        slot_valid;
        logic        slice_done;
        logic [10:0] edges_stored;
    } res_t;

endpackage
`default_nettype wire

// File: hw/rtl/cesc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cesc_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/cesc_front.sv
// Front end: image range registers, item intake and classification.
// Depends on cesc_pkg.
`default_nettype none
module cesc_front import cesc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [63:0] stack_word,
    input  wire logic [7:0]  opcode_byte,
    input  wire logic        opcode_fault,
    input  wire logic [31:0] call_displacement,
    input  wire logic [9:0]  entry_index,
    input  wire logic        slice_last,
    input  wire logic        q_ready,
    output logic             q_push,
    output cmd_t             q_cmd
);
    logic [63:0] image_base_reg;
    logic [63:0] image_end_reg;
    logic [63:0] callee;
    logic        word_in;
    logic        callee_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_base_reg <= '0;
            image_end_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_IMAGE_END)
            begin
                image_end_reg <= cfg_wdata;
            end
            else
            begin
                image_base_reg <= cfg_wdata;
            end
        end
    end

    assign callee    = stack_word + {{32{call_displacement[31]}}, call_displacement};
    assign word_in   = (stack_word >= image_base_reg) && (stack_word < image_end_reg);
    assign callee_in = (callee >= image_base_reg) && (callee < image_end_reg);
    assign in_ready  = q_ready;
    assign q_push    = in_valid && q_ready && (action != ACT_UNUSED);

    always_comb
    begin
        q_cmd.caller_rva  = stack_word[31:0] - 32'd5 - image_base_reg[31:0];
        q_cmd.callee_rva  = callee[31:0] - image_base_reg[31:0];
        q_cmd.entry_index = entry_index;
        q_cmd.last        = slice_last;
        q_cmd.status      = ST_NOT_CODE;
        q_cmd.kind        = KIND_REJECT;
        case (action)
            ACT_RECORD:
            begin
                if (!word_in)
                begin
                    q_cmd.status = ST_NOT_CODE;
                end
                else if (opcode_fault || (opcode_byte != CALL_OPCODE))
                begin
                    q_cmd.status = ST_NO_CALL;
                end
                else if (!callee_in)
                begin
                    q_cmd.status = ST_CALLEE_OUT;
                end
                else
                begin
                    q_cmd.kind = KIND_RECORD;
                end
            end
            ACT_READ:  q_cmd.kind = KIND_READ;
            ACT_CLEAR: q_cmd.kind = KIND_CLEAR;
            default:   q_cmd.kind = KIND_REJECT;
        endcase
    end
endmodule
`default_nettype wire

// File: hw/rtl/cesc_queue.sv
// Short command queue between front and back ends.
// Depends on cesc_pkg.
`default_nettype none
module cesc_queue import cesc_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      push_ready,
    input  wire logic pop,
    output logic      pop_valid,
    output cmd_t      pop_cmd
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   cnt_reg;

    assign push_ready = (cnt_reg != (PW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/cesc_back.sv
// Back end: edge table search, update, read and clear; output register.
// Depends on cesc_pkg and cesc_ram.
`default_nettype none
module cesc_back import cesc_pkg::*; #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    output logic      res_valid,
    input  wire logic res_ready,
    output res_t      res,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0] used_count
);
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    state_t        state_reg, state_next;
    cmd_t          cmd_reg, cmd_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] used_reg, used_next;
    logic          out_valid_reg, out_valid_next;
    res_t          out_reg, out_next;

    logic          re, we;
    logic [AW-1:0] raddr, waddr;
    logic [95:0]   wdata, rdata;
    logic          out_free;
    logic          idx_ok;
    logic          hit;
    logic          at_end;
    logic [31:0]   inc_count;
    logic [63:0]   cmd_key;

    cesc_ram #(.WIDTH(96), .DEPTH(TABLE_ENTRIES)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_free   = !out_valid_reg || res_ready;
    assign idx_ok     = (32'(q_cmd.entry_index) < 32'(used_reg));
    assign cmd_key    = {cmd_reg.caller_rva, cmd_reg.callee_rva};
    assign hit        = (rdata[95:32] == cmd_key);
    assign at_end     = ((CW'(ptr_reg) + 1'b1) == used_reg);
    assign inc_count  = (rdata[31:0] == 32'hFFFF_FFFF) ? rdata[31:0] : rdata[31:0] + 32'd1;
    assign res_valid  = out_valid_reg;
    assign res        = out_reg;
    assign used_count = used_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    if ((q_cmd.kind == KIND_READ) && idx_ok)
                    begin
                        state_next = S_CMP;
                    end
                    else if ((q_cmd.kind == KIND_RECORD) && (used_reg != '0))
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:  state_next = S_CMP;
            S_CMP:
            begin
                if ((cmd_reg.kind == KIND_RECORD) && !hit && !at_end)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        ptr_next       = ptr_reg;
        used_next      = used_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res_ready;
        q_pop          = 1'b0;
        re             = 1'b0;
        raddr          = ptr_reg;
        we             = 1'b0;
        waddr          = ptr_reg;
        wdata          = {cmd_key, inc_count};
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    ptr_next = '0;
                    out_next = '{status: q_cmd.status, caller_rva: 32'd0, callee_rva: 32'd0,
                                 hit_count: 32'd0, slot_valid: 1'b0,
                                 slice_done: q_cmd.last, edges_stored: 11'(used_reg)};
                    case (q_cmd.kind)
                        KIND_REJECT: out_valid_next = 1'b1;
                        KIND_CLEAR:
                        begin
                            used_next             = '0;
                            out_next.status       = ST_CLEARED;
                            out_next.edges_stored = '0;
                            out_valid_next        = 1'b1;
                        end
                        KIND_READ:
                        begin
                            if (idx_ok)
                            begin
                                re    = 1'b1;
                                raddr = AW'(q_cmd.entry_index);
                            end
                            else
                            begin
                                out_next.status = ST_READ;
                                out_valid_next  = 1'b1;
                            end
                        end
                        KIND_RECORD:
                        begin
                            if (used_reg == '0)
                            begin
                                we                    = 1'b1;
                                waddr                 = '0;
                                wdata                 = {q_cmd.caller_rva, q_cmd.callee_rva, 32'd1};
                                used_next             = CW'(1);
                                out_next.status       = ST_INSERTED;
                                out_next.caller_rva   = q_cmd.caller_rva;
                                out_next.callee_rva   = q_cmd.callee_rva;
                                out_next.hit_count    = 32'd1;
                                out_next.slot_valid   = 1'b1;
                                out_next.edges_stored = 11'(CW'(1));
                                out_valid_next        = 1'b1;
                            end
                        end
                        default: q_pop = 1'b1;
                    endcase
                end
            end
            S_RD:
            begin
                re = 1'b1;
            end
            S_CMP:
            begin
                out_next.slice_done   = cmd_reg.last;
                out_next.edges_stored = 11'(used_reg);
                if (cmd_reg.kind == KIND_READ)
                begin
                    out_next.status     = ST_READ;
                    out_next.caller_rva = rdata[95:64];
                    out_next.callee_rva = rdata[63:32];
                    out_next.hit_count  = rdata[31:0];
                    out_next.slot_valid = 1'b1;
                    out_valid_next      = 1'b1;
                end
                else if (hit)
                begin
                    we                  = 1'b1;
                    out_next.status     = ST_INCREMENTED;
                    out_next.caller_rva = cmd_reg.caller_rva;
                    out_next.callee_rva = cmd_reg.callee_rva;
                    out_next.hit_count  = inc_count;
                    out_next.slot_valid = 1'b1;
                    out_valid_next      = 1'b1;
                end
                else if (at_end)
                begin
                    out_next.caller_rva = cmd_reg.caller_rva;
                    out_next.callee_rva = cmd_reg.callee_rva;
                    out_valid_next      = 1'b1;
                    if (used_reg == FULL_COUNT)
                    begin
                        out_next.status     = ST_FULL;
                        out_next.hit_count  = 32'd0;
                        out_next.slot_valid = 1'b0;
                    end
                    else
                    begin
                        we                    = 1'b1;
                        waddr                 = AW'(used_reg);
                        wdata                 = {cmd_key, 32'd1};
                        used_next             = used_reg + 1'b1;
                        out_next.status       = ST_INSERTED;
                        out_next.hit_count    = 32'd1;
                        out_next.slot_valid   = 1'b1;
                        out_next.edges_stored = 11'(used_reg + 1'b1);
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            default: ptr_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        ptr_reg <= ptr_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/call_edge_sample_counter_unit.sv
// Rejects, reads of unused slots, clears and inserts into an empty table are answered
// from the idle state; reads of stored slots pass a RAM read and a compare state; a
// record reads and compares the stored edges one by one, and may wait in the queue.
// The back end takes no new item until it is through with the last; the table search
// through the single read port of the edge RAM sets the pace. A 2-entry queue decouples intake.
// Reset (async, active low) empties the table count, queue and output; the
// table contents are not cleared, slots beyond the count are unused.
`default_nettype none
`include "assert_macros.svh"
module call_edge_sample_counter_unit import cesc_pkg::*; #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [63:0] stack_word,
    input  wire logic [7:0]  opcode_byte,
    input  wire logic        opcode_fault,
    input  wire logic [31:0] call_displacement,
    input  wire logic [9:0]  entry_index,
    input  wire logic        slice_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [31:0]      caller_rva,
    output logic [31:0]      callee_rva,
    output logic [31:0]      hit_count,
    output logic             slot_valid,
    output logic             slice_done,
    output logic [10:0]      edges_stored
);
    logic q_push, q_ready, q_pop, q_valid;
    cmd_t push_cmd, pop_cmd;
    res_t res;
    logic [$clog2(TABLE_ENTRIES+1)-1:0] used_count;

    cesc_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .action            (action),
        .stack_word        (stack_word),
        .opcode_byte       (opcode_byte),
        .opcode_fault      (opcode_fault),
        .call_displacement (call_displacement),
        .entry_index       (entry_index),
        .slice_last        (slice_last),
        .q_ready           (q_ready),
        .q_push            (q_push),
        .q_cmd             (push_cmd)
    );

    cesc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_cmd    (pop_cmd)
    );

    cesc_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (pop_cmd),
        .q_pop      (q_pop),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res        (res),
        .used_count (used_count)
    );

    assign status       = res.status;
    assign caller_rva   = res.caller_rva;
    assign callee_rva   = res.callee_rva;
    assign hit_count    = res.hit_count;
    assign slot_valid   = res.slot_valid;
    assign slice_done   = res.slice_done;
    assign edges_stored = res.edges_stored;

    `ASSERT_CLK(a_used_bound, 32'(used_count) <= TABLE_ENTRIES, "edge count above table size")
    `ASSERT_IMPL(a_clear_empty, out_valid && (status == ST_CLEARED),
        edges_stored == 11'd0, "clear result with edges left")
    `ASSERT_IMPL(a_insert_one, out_valid && (status == ST_INSERTED),
        slot_valid && (hit_count == 32'd1), "insert result without a fresh count")
endmodule
`default_nettype wire

// File: tb/tb_call_edge_sample_counter_unit.sv
// Self-checking testbench for call_edge_sample_counter_unit: directed rows, then random
// stack words, reads and clears, checked against a predictor of the edge table.
// Depends on cesc_pkg and the unit itself.
`timescale 1ns / 100ps
module tb_call_edge_sample_counter_unit;
    import cesc_pkg::*;

    localparam int          N_SLOTS        = 1024;
    localparam longint      CYCLE_LIMIT    = 8_000_000;

    typedef struct {
        logic [1:0]  act;
        logic [63:0] word;
        logic [7:0]  op;
        logic        fault;
        logic [31:0] disp;
        logic [9:0]  idx;
        logic        last;
        bit          typed;
        res_t        want;
    } item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [63:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  action = '0;
    logic [63:0] stack_word = '0;
    logic [7:0]  opcode_byte = '0;
    logic        opcode_fault = 1'b0;
    logic [31:0] call_displacement = '0;
    logic [9:0]  entry_index = '0;
    logic        slice_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [31:0] caller_rva;
    logic [31:0] callee_rva;
    logic [31:0] hit_count;
    logic        slot_valid;
    logic        slice_done;
    logic [10:0] edges_stored;

    call_edge_sample_counter_unit dut (.*);

    // edge table copy
    logic [63:0] img_base, img_end;
    logic [63:0] key_mem [N_SLOTS];
    logic [31:0] hits_mem [N_SLOTS];
    bit          used_mem [N_SLOTS];
    int          edge_total;

    res_t   pending_q [$];
    item_t  rows [$];
    item_t  call_pool [12];
    int     snd_idle, rcv_idle, hold_cycles;
    int     mismatches;
    longint cycles;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic bit in_img(logic [63:0] a);
        return a >= img_base && a < img_end;
    endfunction

    function automatic res_t count_edge(item_t it);
        res_t        r;
        logic [63:0] callee, key;
        logic [31:0] crva, cerva;
        int          free_slot;
        r = '0;
        r.slice_done = it.last;
        free_slot = N_SLOTS;
        case (it.act)
            ACT_RECORD: begin
                if (!in_img(it.word))
                    r.status = ST_NOT_CODE;
                else if (it.fault || it.op != CALL_OPCODE)
                    r.status = ST_NO_CALL;
                else begin
                    callee = it.word + {{32{it.disp[31]}}, it.disp};
                    if (!in_img(callee))
                        r.status = ST_CALLEE_OUT;
                    else begin
                        crva = 32'(it.word - 64'd5 - img_base);
                        cerva = 32'(callee - img_base);
                        key = {crva, cerva};
                        r.caller_rva = crva;
                        r.callee_rva = cerva;
                        r.status = ST_FULL;
                        for (int i = 0; i < N_SLOTS; i++) begin
                            if (used_mem[i] && key_mem[i] == key) begin
                                if (hits_mem[i] != 32'hFFFF_FFFF)
                                    hits_mem[i]++;
                                r.status = ST_INCREMENTED;
                                r.hit_count = hits_mem[i];
                                r.slot_valid = 1'b1;
                                break;
                            end
                            if (!used_mem[i] && free_slot == N_SLOTS)
                                free_slot = i;
                        end
                        if (r.status == ST_FULL && free_slot != N_SLOTS) begin
                            used_mem[free_slot] = 1'b1;
                            key_mem[free_slot] = key;
                            hits_mem[free_slot] = 32'd1;
                            edge_total++;
                            r.status = ST_INSERTED;
                            r.hit_count = 32'd1;
                            r.slot_valid = 1'b1;
                        end
                    end
                end
            end
            ACT_READ: begin
                r.status = ST_READ;
                if (used_mem[it.idx]) begin
                    r.caller_rva = key_mem[it.idx][63:32];
                    r.callee_rva = key_mem[it.idx][31:0];
                    r.hit_count = hits_mem[it.idx];
                    r.slot_valid = 1'b1;
                end
            end
            ACT_CLEAR: begin
                for (int i = 0; i < N_SLOTS; i++)
                    used_mem[i] = 1'b0;
                edge_total = 0;
                r.status = ST_CLEARED;
            end
            default: ;
        endcase
        r.edges_stored = 11'(edge_total);
        return r;
    endfunction

    function automatic item_t mk(logic [1:0] act, logic [63:0] word, logic [7:0] op,
                                 logic fault, logic [31:0] disp, logic [9:0] idx,
                                 logic last, bit typed = 0, logic [2:0] st = '0,
                                 logic [31:0] crva = '0, logic [31:0] cerva = '0,
                                 logic [31:0] hc = '0, logic sv = 0, int es = 0);
        item_t it;
        it.act = act;
        it.word = word;
        it.op = op;
        it.fault = fault;
        it.disp = disp;
        it.idx = idx;
        it.last = last;
        it.typed = typed;
        it.want = '{st, crva, cerva, hc, sv, last, 11'(es)};
        return it;
    endfunction

    // well-formed call whose site and target both fall in the image
    function automatic item_t good_call();
        logic [63:0] reach, w, t;
        reach = (img_end - img_base > 64'h10_0000) ? 64'h10_0000 : img_end - img_base;
        w = img_base + 64'($urandom_range(32'(reach - 1)));
        t = img_base + 64'($urandom_range(32'(reach - 1)));
        return mk(ACT_RECORD, w, CALL_OPCODE, 1'b0, 32'(t - w), 10'($urandom),
                  1'($urandom_range(7) == 0));
    endfunction

    function automatic item_t rand_item();
        item_t it;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 55)
            it = call_pool[$urandom_range(11)];
        else if (pick < 65)
            it = good_call();
        else if (pick < 80) begin
            it = good_call();
            case ($urandom_range(3))
                0: it.word = {$urandom, $urandom};
                1: it.op = 8'($urandom);
                2: it.fault = 1'b1;
                default: it.disp = $urandom;
            endcase
        end else if (pick < 95)
            it = mk(ACT_READ, {$urandom, $urandom}, 8'($urandom), 1'($urandom),
                    $urandom, $urandom_range(3) == 0 ? 10'($urandom) :
                    10'($urandom_range(15)), 1'($urandom));
        else if (pick < 98)
            it = mk(ACT_CLEAR, {$urandom, $urandom}, 8'($urandom), 1'($urandom),
                    $urandom, 10'($urandom), 1'($urandom));
        else
            it = mk(ACT_UNUSED, {$urandom, $urandom}, 8'($urandom), 1'($urandom),
                    $urandom, 10'($urandom), 1'($urandom));
        it.last = 1'($urandom_range(7) == 0);
        return it;
    endfunction

    task automatic send(item_t it);
        res_t r;
        while ($urandom_range(99) < snd_idle) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        action = it.act;
        stack_word = it.word;
        opcode_byte = it.op;
        opcode_fault = it.fault;
        call_displacement = it.disp;
        entry_index = it.idx;
        slice_last = it.last;
        in_valid = 1'b1;
        #1;
        while (!in_ready) begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
        r = count_edge(it);
        if (it.act != ACT_UNUSED)
            pending_q.push_back(it.typed ? it.want : r);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [63:0] v);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        if (idx == REG_IMAGE_BASE)
            img_base = v;
        else
            img_end = v;
    endtask

    task automatic set_range(logic [63:0] b, logic [63:0] e);
        write_reg(REG_IMAGE_BASE, b);
        write_reg(REG_IMAGE_END, e);
        if (e > b)
            foreach (call_pool[i])
                call_pool[i] = good_call();
    endtask

    task automatic random_run(int n);
        repeat (n) send(rand_item());
    endtask

    // receiver
    initial begin
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                out_ready = 1'b0;
                hold_cycles--;
            end else
                out_ready = $urandom_range(99) >= rcv_idle;
        end
    end

    // result checker
    initial begin
        res_t got, want;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                got = '{status, caller_rva, callee_rva, hit_count, slot_valid,
                        slice_done, edges_stored};
                if (pending_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: %p", got);
                end else begin
                    want = pending_q.pop_front();
                    if (got.status !== want.status || got.caller_rva !== want.caller_rva ||
                        got.callee_rva !== want.callee_rva ||
                        got.hit_count !== want.hit_count ||
                        got.slot_valid !== want.slot_valid ||
                        got.slice_done !== want.slice_done ||
                        got.edges_stored !== want.edges_stored) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at %0t: expected %p, got %p", $time, want, got);
                    end
                end
            end
        end
    end

    initial begin
        logic [63:0] b;
        img_base = '0;
        img_end = '0;
        edge_total = 0;
        foreach (used_mem[i])
            used_mem[i] = 1'b0;
        snd_idle = 15;
        rcv_idle = 55;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        b = 64'h40_0000;
        rows.push_back(mk(ACT_READ, '0, '0, 0, '0, 10'd0, 0, 1, ST_READ));
        set_range(b, 64'h50_0000);
        rows.push_back(mk(ACT_RECORD, b - 1, CALL_OPCODE, 0, 32'h10, '0, 0, 1, ST_NOT_CODE));
        rows.push_back(mk(ACT_RECORD, 64'h50_0000, CALL_OPCODE, 0, '0, '0, 1, 1,
                          ST_NOT_CODE));
        rows.push_back(mk(ACT_RECORD, '1, 8'hFF, 1, '1, '1, 0, 1, ST_NOT_CODE));
        rows.push_back(mk(ACT_RECORD, b + 'h100, 8'h90, 0, 32'h10, '0, 0, 1, ST_NO_CALL));
        rows.push_back(mk(ACT_RECORD, b + 'h100, CALL_OPCODE, 1, 32'h10, '0, 0, 1,
                          ST_NO_CALL));
        rows.push_back(mk(ACT_RECORD, b + 'h1000, CALL_OPCODE, 0, 32'h7FFF_FFFF, '0, 0, 1,
                          ST_CALLEE_OUT));
        rows.push_back(mk(ACT_RECORD, b + 'h1000, CALL_OPCODE, 0, 32'h8000_0000, '0, 0, 1,
                          ST_CALLEE_OUT));
        rows.push_back(mk(ACT_RECORD, b + 'h1005, CALL_OPCODE, 0, 32'h10, '0, 0, 1,
                          ST_INSERTED, 32'h1000, 32'h1015, 32'd1, 1, 1));
        rows.push_back(mk(ACT_RECORD, b + 'h1005, CALL_OPCODE, 0, 32'h10, '0, 1, 1,
                          ST_INCREMENTED, 32'h1000, 32'h1015, 32'd2, 1, 1));
        rows.push_back(mk(ACT_RECORD, b, CALL_OPCODE, 0, 32'h20, '0, 0));
        rows.push_back(mk(ACT_RECORD, 64'h4F_FFFF, CALL_OPCODE, 0, 32'hFFF0_0001, '0, 0));
        rows.push_back(mk(ACT_RECORD, b + 'h2000, CALL_OPCODE, 0, 32'hFFFF_F000, '0, 0));
        rows.push_back(mk(ACT_READ, '0, '0, 0, '0, 10'd0, 0));
        rows.push_back(mk(ACT_READ, '0, '0, 0, '0, 10'd2, 1));
        rows.push_back(mk(ACT_READ, '1, '1, 1, '1, 10'd1023, 0));
        rows.push_back(mk(ACT_UNUSED, '1, '1, 1, '1, '1, 1));
        rows.push_back(mk(ACT_RECORD, b + 'h1005, CALL_OPCODE, 0, 32'h10, '0, 0));
        rows.push_back(mk(ACT_CLEAR, '1, '1, 1, '1, '1, 1, 1, ST_CLEARED));
        rows.push_back(mk(ACT_READ, '0, '0, 0, '0, 10'd0, 0, 1, ST_READ));
        rows.push_back(mk(ACT_RECORD, b + 'h1005, CALL_OPCODE, 0, 32'h10, '0, 0, 1,
                          ST_INSERTED, 32'h1000, 32'h1015, 32'd1, 1, 1));
        send(rows[0]);
        foreach (rows[i])
            if (i > 0)
                send(rows[i]);
        random_run(250);
        drain();

        // image at the top of the address space, receiver mostly ready
        snd_idle = 55;
        rcv_idle = 15;
        set_range(64'hFFFF_FFFF_FFF0_0000, '1);
        hold_cycles = 400;
        random_run(250);
        drain();

        // fill every slot, then overflow
        snd_idle = 0;
        rcv_idle = 0;
        set_range(64'h1000, 64'h20_0000);
        send(mk(ACT_CLEAR, '0, '0, 0, '0, '0, 0));
        for (int i = 0; i < N_SLOTS + 4; i++)
            send(mk(ACT_RECORD, 64'h2000 + 64'(i), CALL_OPCODE, 0, 32'h100, '0,
                    1'(i == N_SLOTS - 1)));
        repeat (20)
            send(mk(ACT_READ, '0, '0, 0, '0, 10'($urandom), 0));
        send(mk(ACT_RECORD, 64'h2000, CALL_OPCODE, 0, 32'h100, '0, 0));
        send(mk(ACT_CLEAR, '0, '0, 0, '0, '0, 1));
        drain();

        // inverted range, then the whole address space
        snd_idle = 15;
        rcv_idle = 55;
        set_range(64'h10_0000_0000, 64'h10);
        repeat (30)
            send(mk(ACT_RECORD, {$urandom, $urandom}, CALL_OPCODE, 0, $urandom, '0, 0));
        drain();
        snd_idle = 0;
        rcv_idle = 0;
        set_range('0, '1);
        random_run(200);
        drain();

        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
